// ===== design/lowest_free_id_allocator_top_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef LOWEST_FREE_ID_ALLOCATOR_TOP_MACROS_SVH
`define LOWEST_FREE_ID_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LFIA_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LFIA_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lfia_pkg.sv =====
// Types and constants of the lowest-free ID allocator.
package lfia_pkg;

  localparam int ID_W     = 8;
  localparam int WORD_W   = 64;
  localparam int POS_W    = 6;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLAIM   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IN_USE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd3;

  localparam logic [ID_W-1:0] FIRST_ID = 8'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN_FREE,
    S_SCAN_HIGH
  } state_t;

  typedef enum logic {
    DIR_LOW,
    DIR_HIGH
  } find_dir_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } find_res_t;

endpackage

// ===== design/lfia_find.sv =====
// Shared bit finder: lowest or highest set bit of one 64-bit map word.
module lfia_find
  import lfia_pkg::*;
(
  input  logic [WORD_W-1:0] word,
  input  find_dir_t         dir,
  output find_res_t         res
);

  always_comb begin
    logic [WORD_W-1:0] w;
    logic [POS_W-1:0]  lo;
    // highest-set search reuses the lowest-set encoder on the reversed word
    for (int i = 0; i < WORD_W; i++) begin
      w[i] = (dir == DIR_HIGH) ? word[WORD_W-1-i] : word[i];
    end
    lo = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        lo = POS_W'(i);
      end
    end
    res.found = |w;
    res.pos   = (dir == DIR_HIGH) ? (POS_W'(WORD_W - 1) - lo) : lo;
  end

endmodule

// ===== design/lowest_free_id_allocator_top.sv =====
// Top level of the lowest-free ID allocator.
//
// Usage: drive mode and req_id with start high; the request is taken at a
// rising edge where start is high and busy is low. busy stays high until the
// request has finished. The result (granted_id, status) is on the ports for
// exactly one cycle with done high; the receiver cannot stall it.
// Claim and release: the request is carried out in S_EXEC; done is registered.
// Allocate: the freed map is scanned low to high, then the assigned map high
// to low, one 64-bit word per cycle through one shared bit finder. With W map
// words (W = 4 at NUM_IDS >= 256) the scan stops at the first word with a hit
// or after every word of both maps. busy drops in the cycle done is high, so
// the next request can be taken right then.
// Reset (rst, synchronous) clears both maps at once and returns to idle; no
// clearing pass is needed.
`include "lowest_free_id_allocator_top_macros.svh"

module lowest_free_id_allocator_top
  import lfia_pkg::*;
#(
  parameter int NUM_IDS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [MODE_W-1:0]   mode,
  input  logic [ID_W-1:0]     req_id,
  output logic                done,
  output logic [ID_W-1:0]     granted_id,
  output logic [STATUS_W-1:0] status
);

  localparam int ID_SPAN   = (NUM_IDS < 256) ? NUM_IDS : 256;
  localparam int NWORDS    = (ID_SPAN + WORD_W - 1) / WORD_W;
  localparam int MAP_BITS  = NWORDS * WORD_W;
  localparam int MAP_IDX_W = $clog2(MAP_BITS);
  localparam int WIDX_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int SUM_W     = WIDX_W + POS_W + 1;

  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(NWORDS - 1);
  localparam logic [SUM_W-1:0]  SPAN_S    = SUM_W'(ID_SPAN);
  localparam logic [ID_W:0]     SPAN_ID   = (ID_W + 1)'(ID_SPAN);

  state_t               state, state_next;
  logic [WIDX_W-1:0]    widx, widx_next;
  logic [MODE_W-1:0]    mode_q;
  logic [ID_W-1:0]      id_q;
  logic [MAP_BITS-1:0]  assigned_map;
  logic [MAP_BITS-1:0]  freed_map;

  logic [WORD_W-1:0]    word_sel;
  find_dir_t            dir;
  find_res_t            fres;
  logic [SUM_W-1:0]     hit_pos;
  logic [SUM_W-1:0]     pick_hi;
  logic [MAP_IDX_W-1:0] id_idx;
  logic                 id_ok;
  logic                 asg_bit;
  logic                 accept;

  logic                 res_valid;
  logic [ID_W-1:0]      res_id;
  logic [STATUS_W-1:0]  res_status;
  logic [MAP_IDX_W-1:0] wr_idx;
  logic                 set_asg, clr_asg, set_fr, clr_fr;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  // one map word per cycle into the shared finder
  assign dir      = (state == S_SCAN_HIGH) ? DIR_HIGH : DIR_LOW;
  assign word_sel = (state == S_SCAN_HIGH) ? assigned_map[widx*WORD_W +: WORD_W]
                                           : freed_map[widx*WORD_W +: WORD_W];

  lfia_find u_find (
    .word (word_sel),
    .dir  (dir),
    .res  (fres)
  );

  assign hit_pos = SUM_W'({widx, fres.pos});
  assign pick_hi = hit_pos + SUM_W'(1);

  assign id_idx  = id_q[MAP_IDX_W-1:0];
  assign id_ok   = (id_q != '0) && ({1'b0, id_q} < SPAN_ID);
  assign asg_bit = assigned_map[id_idx];

  // next state
  always_comb begin
    state_next = state;
    widx_next  = widx;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (mode == MODE_ALLOC) ? S_SCAN_FREE : S_EXEC;
          widx_next  = '0;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      S_SCAN_FREE: begin
        if (fres.found) begin
          state_next = S_IDLE;
        end else if (widx == LAST_WORD) begin
          state_next = S_SCAN_HIGH;
        end else begin
          widx_next = widx + WIDX_W'(1);
        end
      end
      S_SCAN_HIGH: begin
        if (fres.found || (widx == '0)) begin
          state_next = S_IDLE;
        end else begin
          widx_next = widx - WIDX_W'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // actions and result
  always_comb begin
    res_valid  = 1'b0;
    res_id     = '0;
    res_status = ST_INVALID;
    wr_idx     = id_idx;
    set_asg    = 1'b0;
    clr_asg    = 1'b0;
    set_fr     = 1'b0;
    clr_fr     = 1'b0;
    unique case (state)
      S_EXEC: begin
        res_valid = 1'b1;
        priority if (mode_q == MODE_CLAIM) begin
          if (!id_ok) begin
            res_status = ST_INVALID;
          end else if (asg_bit) begin
            res_status = ST_IN_USE;
          end else begin
            clr_fr     = 1'b1;
            set_asg    = 1'b1;
            res_id     = id_q;
            res_status = ST_OK;
          end
        end else if (mode_q == MODE_RELEASE) begin
          if (id_ok && asg_bit) begin
            clr_asg    = 1'b1;
            set_fr     = 1'b1;
            res_status = ST_OK;
          end
        end else begin
          res_status = ST_INVALID;
        end
      end
      S_SCAN_FREE: begin
        if (fres.found) begin
          wr_idx     = hit_pos[MAP_IDX_W-1:0];
          clr_fr     = 1'b1;
          set_asg    = 1'b1;
          res_valid  = 1'b1;
          res_id     = ID_W'(hit_pos);
          res_status = ST_OK;
        end
      end
      S_SCAN_HIGH: begin
        if (fres.found) begin
          res_valid = 1'b1;
          if (pick_hi >= SPAN_S) begin
            res_status = ST_EXHAUSTED;
          end else begin
            wr_idx     = pick_hi[MAP_IDX_W-1:0];
            set_asg    = 1'b1;
            res_id     = ID_W'(pick_hi);
            res_status = ST_OK;
          end
        end else if (widx == '0) begin
          // nothing assigned at all: start from the first ID
          wr_idx     = MAP_IDX_W'(FIRST_ID);
          set_asg    = 1'b1;
          res_valid  = 1'b1;
          res_id     = FIRST_ID;
          res_status = ST_OK;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      widx         <= '0;
      done         <= 1'b0;
      assigned_map <= '0;
      freed_map    <= '0;
    end else begin
      state <= state_next;
      widx  <= widx_next;
      done  <= res_valid;
      if (set_asg) begin
        assigned_map[wr_idx] <= 1'b1;
      end
      if (clr_asg) begin
        assigned_map[wr_idx] <= 1'b0;
      end
      if (set_fr) begin
        freed_map[wr_idx] <= 1'b1;
      end
      if (clr_fr) begin
        freed_map[wr_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= mode;
      id_q   <= req_id;
    end
    if (res_valid) begin
      granted_id <= res_id;
      status     <= res_status;
    end
  end

  `LFIA_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy, "request taken but busy not raised")
  `LFIA_ASSERT_NOW(a_maps_disjoint, clk, rst, 1'b1, (assigned_map & freed_map) == '0, "ID both assigned and freed")
  `LFIA_ASSERT_NOW(a_grant_ok, clk, rst, done && (status != ST_OK), granted_id == '0, "ID granted with error status")
  `LFIA_ASSERT_NOW(a_grant_held, clk, rst, done && (granted_id != '0), assigned_map[granted_id[MAP_IDX_W-1:0]], "granted ID not marked assigned")

endmodule

// ===== bench/lowest_free_id_allocator_top_test.sv =====
// Directed and randomized self-checking testbench for the lowest-free ID allocator.
import lfia_pkg::*;

class allocator_scoreboard;
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [STATUS_W-1:0] st;
  } grant_t;

  bit [255:0] held_map;
  bit [255:0] freed_map;
  grant_t     grant_q[$];
  int         errors;
  int         checked;
  int         status_count[4];

  function new();
    held_map  = '0;
    freed_map = '0;
    errors    = 0;
    checked   = 0;
    foreach (status_count[i]) status_count[i] = 0;
  endfunction

  function int pending();
    return grant_q.size();
  endfunction

  function int unsigned lowest_freed();
    for (int i = 1; i < 256; i++)
      if (freed_map[i]) return i;
    return 0;
  endfunction

  function int unsigned highest_held();
    for (int i = 255; i >= 1; i--)
      if (held_map[i]) return i;
    return 0;
  endfunction

  // Random set bit of a map, 0 if the map is empty.
  function int unsigned pick_set(bit [255:0] map);
    int n;
    int k;
    n = 0;
    for (int i = 1; i < 256; i++) n += map[i];
    if (n == 0) return 0;
    k = $urandom_range(n - 1, 0);
    for (int i = 1; i < 256; i++)
      if (map[i]) begin
        if (k == 0) return i;
        k--;
      end
    return 0;
  endfunction

  function void note_request(logic [MODE_W-1:0] m, logic [ID_W-1:0] rid);
    grant_t      g;
    int unsigned pick;
    g.id = '0;
    g.st = ST_INVALID;
    case (m)
      MODE_ALLOC: begin
        pick = lowest_freed();
        if (pick != 0) begin
          freed_map[pick] = 1'b0;
        end else begin
          pick = highest_held() + 1;
        end
        if (pick >= 256) begin
          g.st = ST_EXHAUSTED;
        end else begin
          held_map[pick] = 1'b1;
          g.id = pick[ID_W-1:0];
          g.st = ST_OK;
        end
      end
      MODE_CLAIM: begin
        if (rid == '0) begin
          g.st = ST_INVALID;
        end else if (held_map[rid]) begin
          g.st = ST_IN_USE;
        end else begin
          freed_map[rid] = 1'b0;
          held_map[rid]  = 1'b1;
          g.id = rid;
          g.st = ST_OK;
        end
      end
      MODE_RELEASE: begin
        if (rid != '0 && held_map[rid]) begin
          held_map[rid]  = 1'b0;
          freed_map[rid] = 1'b1;
          g.st = ST_OK;
        end
      end
      default: g.st = ST_INVALID;
    endcase
    status_count[g.st]++;
    grant_q.push_back(g);
  endfunction

  task report_mismatch(string msg);
    errors++;
    if (errors <= 30) $display("MISMATCH: %s", msg);
  endtask

  task check_result(logic [ID_W-1:0] gid, logic [STATUS_W-1:0] st);
    grant_t g;
    checked++;
    if (grant_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result id=%0d status=%0d", gid, st));
    end else begin
      g = grant_q.pop_front();
      if (gid !== g.id)
        report_mismatch($sformatf("result %0d: granted_id %0d, expected %0d",
                                  checked, gid, g.id));
      if (st !== g.st)
        report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                  checked, st, g.st));
    end
  endtask
endclass

module lowest_free_id_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1400;
  localparam int LIMIT_CYCLES = 400000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [MODE_W-1:0]   mode = MODE_ALLOC;
  logic [ID_W-1:0]     req_id = '0;
  logic                busy;
  logic                done;
  logic [ID_W-1:0]     granted_id;
  logic [STATUS_W-1:0] status;

  allocator_scoreboard sb = new();
  int cycles = 0;

  lowest_free_id_allocator_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .req_id(req_id),
    .done(done),
    .granted_id(granted_id),
    .status(status)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(granted_id, status);
  end

  // Request stays up until an edge sees busy low.
  task send_request(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] rid);
    start  <= 1'b1;
    mode   <= m;
    req_id <= rid;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(m, rid);
  endtask

  task idle_for(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function int gap_len();
    int r;
    r = $urandom_range(99, 0);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(9, 4);
    return $urandom_range(60, 20);
  endfunction

  initial begin
    int          r;
    int unsigned rid;
    bit          no_gaps;
    logic [MODE_W-1:0] m;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: sequential grants, freed reuse, sentinel, in-use, top of range.
    send_request(MODE_ALLOC, 8'hFF);
    send_request(MODE_ALLOC, 8'h00);
    send_request(MODE_ALLOC, 8'h00);
    send_request(MODE_RELEASE, 8'd2);
    send_request(MODE_ALLOC, 8'h00);
    send_request(MODE_RELEASE, 8'd0);
    send_request(MODE_CLAIM, 8'd0);
    send_request(MODE_RELEASE, 8'd200);
    send_request(MODE_CLAIM, 8'd3);
    send_request(MODE_CLAIM, 8'd255);
    send_request(MODE_ALLOC, 8'h00);
    drain_results();
    send_request(MODE_RELEASE, 8'd1);
    send_request(MODE_RELEASE, 8'd3);
    send_request(MODE_ALLOC, 8'h00);
    send_request(MODE_ALLOC, 8'h00);
    send_request(MODE_ALLOC, 8'h00);
    send_request(MODE_RELEASE, 8'd255);
    send_request(MODE_ALLOC, 8'h00);
    send_request(MODE_CLAIM, 8'd128);
    send_request(MODE_RELEASE, 8'd128);
    send_request(MODE_CLAIM, 8'd128);
    send_request(MODE_RELEASE, 8'd255);
    send_request(MODE_RELEASE, 8'd128);
    send_request(MODE_ALLOC, 8'h00);
    send_request(MODE_ALLOC, 8'h00);
    idle_for(5);

    no_gaps = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) no_gaps = ($urandom_range(2, 0) == 0);
      if (n % 250 == 249) drain_results();
      r   = $urandom_range(99, 0);
      rid = $urandom_range(255, 0);
      if (r < 40) begin
        m = MODE_ALLOC;
      end else if (r < 65) begin
        m = MODE_RELEASE;
        rid = sb.pick_set(sb.held_map);
      end else if (r < 78) begin
        m = MODE_CLAIM;
      end else if (r < 86) begin
        m = MODE_RELEASE;
      end else if (r < 93) begin
        m = MODE_CLAIM;
        rid = sb.pick_set(sb.freed_map);
      end else begin
        m = ($urandom_range(1, 0) == 0) ? MODE_CLAIM : MODE_RELEASE;
        rid = $urandom_range(255, 240);
      end
      send_request(m, rid[ID_W-1:0]);
      if (!no_gaps) idle_for(gap_len());
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    $display("Covered %0d requests (directed, then random alloc/claim/release mix)",
             sb.checked);
    $display("Outcomes: %0d ok, %0d in use, %0d exhausted, %0d invalid",
             sb.status_count[ST_OK], sb.status_count[ST_IN_USE],
             sb.status_count[ST_EXHAUSTED], sb.status_count[ST_INVALID]);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
